### rtl/dts_pkg.sv
// ----------------------------------------------------------------------------
// dts_pkg - shared constants and helpers for date_time_to_seconds
// Calendar constants, register offsets and the month-to-days table.
// ----------------------------------------------------------------------------
`default_nettype none

package dts_pkg;

  // field and internal widths
  localparam int unsigned YEAR_W  = 12;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned HOUR_W  = 5;
  localparam int unsigned MIN_W   = 6;
  localparam int unsigned SEC_W   = 6;
  localparam int unsigned OUT_W   = 32;
  localparam int unsigned FOURS_W = 11;   // multiples of four below a 12-bit year
  localparam int unsigned MDAYS_W = 9;    // days before a month, at most 366
  localparam int unsigned DAYS_W  = 21;   // whole-year days plus month days plus day
  localparam int unsigned HOURS_W = 26;   // days * 24 + hour

  // calendar constants
  localparam logic [8:0] DAYS_PER_YEAR = 9'd365;
  localparam logic [4:0] HOURS_PER_DAY = 5'd24;
  localparam logic [5:0] MINS_PER_HOUR = 6'd60;
  localparam logic [5:0] SECS_PER_MIN  = 6'd60;

  // configuration register map
  localparam int unsigned PADDR_W      = 3;
  localparam logic        REG_EPOCH    = 1'b0;   // register index, paddr[2]
  localparam logic [11:0] EPOCH_RESET  = 12'd1970;

  // days in the months before the given one; month zero adds none,
  // months above twelve add the whole year
  function automatic logic [MDAYS_W-1:0] days_before_month(
    input logic [MONTH_W-1:0] month,
    input logic               leap
  );
    logic [MDAYS_W-1:0] base;
    logic               feb_done;
    begin
      feb_done = (month >= 4'd3);
      unique case (month)
        4'd0:    base = 9'd0;
        4'd1:    base = 9'd0;
        4'd2:    base = 9'd31;
        4'd3:    base = 9'd59;
        4'd4:    base = 9'd90;
        4'd5:    base = 9'd120;
        4'd6:    base = 9'd151;
        4'd7:    base = 9'd181;
        4'd8:    base = 9'd212;
        4'd9:    base = 9'd243;
        4'd10:   base = 9'd273;
        4'd11:   base = 9'd304;
        4'd12:   base = 9'd334;
        default: base = 9'd365;
      endcase
      days_before_month = base + {8'd0, (leap && feb_done)};
    end
  endfunction

endpackage

`default_nettype wire

### rtl/date_time_to_seconds.sv
// ----------------------------------------------------------------------------
// date_time_to_seconds - calendar date and time to a seconds count
// Five-stage pipeline: day count, then hours, minutes and seconds scaling.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake             payload
//  in       input      in_valid / in_stall   year month day hour minute second
//  out      output     out_valid / out_stall total_seconds
//  cfg      input      APB psel/penable      epoch_year at byte address 0
//
// One item per cycle sustained while out_stall stays low; an accepted item
// passes through every stage register in turn, and out_valid is the valid bit of stage 5.
// Stages: year/month lookup, day sum (x365), x24, x60, x60 into output register.
// Each stage holds its item only while the stage after it is full and blocked,
// so bubbles close up under a stall and in_stall rises only when all are full.
// Synchronous active-low reset clears the valid bits and sets epoch_year 1970.
//
`default_nettype none

module date_time_to_seconds (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // input channel
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [dts_pkg::YEAR_W-1:0]         in_year,
  input  wire logic [dts_pkg::MONTH_W-1:0]        in_month,
  input  wire logic [dts_pkg::DAY_W-1:0]          in_day,
  input  wire logic [dts_pkg::HOUR_W-1:0]         in_hour,
  input  wire logic [dts_pkg::MIN_W-1:0]          in_minute,
  input  wire logic [dts_pkg::SEC_W-1:0]          in_second,
  // result channel
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic [dts_pkg::OUT_W-1:0]               out_total_seconds,
  // configuration port
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [dts_pkg::PADDR_W-1:0]        paddr,
  input  wire logic [31:0]                        pwdata,
  output logic [31:0]                             prdata,
  output logic                                    pready
);

  localparam int unsigned DAYS_W  = dts_pkg::DAYS_W;
  localparam int unsigned HOURS_W = dts_pkg::HOURS_W;
  localparam int unsigned OUT_W   = dts_pkg::OUT_W;

  // configuration register
  logic [dts_pkg::YEAR_W-1:0] epoch_r;
  logic                       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      epoch_r <= dts_pkg::EPOCH_RESET;
    end else if (cfg_wr && (paddr[2] == dts_pkg::REG_EPOCH)) begin
      epoch_r <= pwdata[dts_pkg::YEAR_W-1:0];
    end
  end

  // register read
  always_comb begin
    if (paddr[2] == dts_pkg::REG_EPOCH) begin
      prdata = {20'd0, epoch_r};
    end else begin
      prdata = 32'd0;
    end
  end

  // stage valids and per-stage advance
  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic v1_nxt, v2_nxt, v3_nxt, v4_nxt, v5_nxt;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  assign rdy5     = !v5_r || !out_stall;
  assign rdy4     = !v4_r || rdy5;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_stall = !rdy1;

  always_comb begin
    v1_nxt = rdy1 ? in_valid : v1_r;
    v2_nxt = rdy2 ? v1_r     : v2_r;
    v3_nxt = rdy3 ? v2_r     : v3_r;
    v4_nxt = rdy4 ? v3_r     : v4_r;
    v5_nxt = rdy5 ? v4_r     : v5_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
      v4_r <= v4_nxt;
      v5_r <= v5_nxt;
    end
  end

  // stage 1: whole years, leap days between years, days of earlier months
  logic [dts_pkg::YEAR_W-1:0]  s1_years_nxt, s1_years_r;
  logic [dts_pkg::FOURS_W-1:0] s1_leaps_nxt, s1_leaps_r;
  logic [dts_pkg::MDAYS_W-1:0] s1_mdays_nxt, s1_mdays_r;
  logic [dts_pkg::DAY_W-1:0]   s1_day_r;
  logic [dts_pkg::HOUR_W-1:0]  s1_hour_r;
  logic [dts_pkg::MIN_W-1:0]   s1_minute_r;
  logic [dts_pkg::SEC_W-1:0]   s1_second_r;
  logic [dts_pkg::YEAR_W:0]    year_up, epoch_up;
  logic [dts_pkg::FOURS_W-1:0] fours_year, fours_epoch;

  always_comb begin
    year_up      = {1'b0, in_year} + 13'd3;
    epoch_up     = {1'b0, epoch_r} + 13'd3;
    fours_year   = year_up[dts_pkg::YEAR_W:2];
    fours_epoch  = epoch_up[dts_pkg::YEAR_W:2];
    s1_mdays_nxt = dts_pkg::days_before_month(in_month, (in_year[1:0] == 2'd0));
    if (in_year > epoch_r) begin
      s1_years_nxt = in_year - epoch_r;
      s1_leaps_nxt = fours_year - fours_epoch;
    end else begin
      s1_years_nxt = '0;
      s1_leaps_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_years_r  <= s1_years_nxt;
      s1_leaps_r  <= s1_leaps_nxt;
      s1_mdays_r  <= s1_mdays_nxt;
      s1_day_r    <= in_day;
      s1_hour_r   <= in_hour;
      s1_minute_r <= in_minute;
      s1_second_r <= in_second;
    end
  end

  // stage 2: total day count
  logic [dts_pkg::DAYS_W-1:0] s2_days_nxt, s2_days_r;
  logic [dts_pkg::HOUR_W-1:0] s2_hour_r;
  logic [dts_pkg::MIN_W-1:0]  s2_minute_r;
  logic [dts_pkg::SEC_W-1:0]  s2_second_r;

  assign s2_days_nxt = DAYS_W'(DAYS_W'(s1_years_r) * DAYS_W'(dts_pkg::DAYS_PER_YEAR))
                     + DAYS_W'(s1_leaps_r) + DAYS_W'(s1_mdays_r) + DAYS_W'(s1_day_r);

  always_ff @(posedge clk) begin
    if (rdy2) begin
      s2_days_r   <= s2_days_nxt;
      s2_hour_r   <= s1_hour_r;
      s2_minute_r <= s1_minute_r;
      s2_second_r <= s1_second_r;
    end
  end

  // stage 3: hours
  logic [dts_pkg::HOURS_W-1:0] s3_hours_nxt, s3_hours_r;
  logic [dts_pkg::MIN_W-1:0]   s3_minute_r;
  logic [dts_pkg::SEC_W-1:0]   s3_second_r;

  assign s3_hours_nxt = HOURS_W'(HOURS_W'(s2_days_r) * HOURS_W'(dts_pkg::HOURS_PER_DAY))
                      + HOURS_W'(s2_hour_r);

  always_ff @(posedge clk) begin
    if (rdy3) begin
      s3_hours_r  <= s3_hours_nxt;
      s3_minute_r <= s2_minute_r;
      s3_second_r <= s2_second_r;
    end
  end

  // stage 4: minutes, wrapping at 32 bits
  logic [dts_pkg::OUT_W-1:0] s4_mins_nxt, s4_mins_r;
  logic [dts_pkg::SEC_W-1:0] s4_second_r;

  assign s4_mins_nxt = OUT_W'(OUT_W'(s3_hours_r) * OUT_W'(dts_pkg::MINS_PER_HOUR))
                     + OUT_W'(s3_minute_r);

  always_ff @(posedge clk) begin
    if (rdy4) begin
      s4_mins_r   <= s4_mins_nxt;
      s4_second_r <= s3_second_r;
    end
  end

  // stage 5: seconds into the output register
  logic [dts_pkg::OUT_W-1:0] s5_secs_nxt, s5_secs_r;

  assign s5_secs_nxt = OUT_W'(s4_mins_r * OUT_W'(dts_pkg::SECS_PER_MIN))
                     + OUT_W'(s4_second_r);

  always_ff @(posedge clk) begin
    if (rdy5) begin
      s5_secs_r <= s5_secs_nxt;
    end
  end

  assign out_valid         = v5_r;
  assign out_total_seconds = s5_secs_r;

endmodule

`default_nettype wire

### rtl/dts_checker.sv
// ----------------------------------------------------------------------------
// dts_checker - port-level checks for date_time_to_seconds
// Watches the channel handshakes and reset behavior at the top-level ports.
// ----------------------------------------------------------------------------
`default_nettype none

module dts_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [31:0] out_total_seconds
);

  // a result held under stall stays offered
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("out_valid dropped while stalled");

  // a stalled result keeps its value
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_total_seconds))
    else $error("out_total_seconds changed while stalled");

  // the pipeline comes out of reset empty
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // input backs up only when the result side is full and blocked
  assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("in_stall without a blocked result");

endmodule

bind date_time_to_seconds dts_checker u_dts_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_total_seconds (out_total_seconds)
);

`default_nettype wire

### sim/date_time_to_seconds_tb.sv
// ----------------------------------------------------------------------------
// date_time_to_seconds_tb - self-checking bench for date_time_to_seconds
// Drives calendar timestamps through the valid/stall input channel, predicts
// each seconds count from its own model of the day and time arithmetic and
// checks every result transfer in order. The epoch register is rewritten
// between phases, covering both ends of its range and values outside it.
// ----------------------------------------------------------------------------
`default_nettype none

module date_time_to_seconds_tb;

  localparam int unsigned CLK_HALF    = 5;
  localparam int unsigned PIPE_DRAIN  = 12;      // idle margin after the last expected result
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned PHASE_ITEMS = 75;
  localparam logic [dts_pkg::PADDR_W-1:0] EPOCH_ADDR = {dts_pkg::REG_EPOCH, 2'b00};

  typedef struct packed {
    logic [dts_pkg::YEAR_W-1:0]  year;
    logic [dts_pkg::MONTH_W-1:0] month;
    logic [dts_pkg::DAY_W-1:0]   day;
    logic [dts_pkg::HOUR_W-1:0]  hour;
    logic [dts_pkg::MIN_W-1:0]   minute;
    logic [dts_pkg::SEC_W-1:0]   second;
  } stamp_t;

  // expected seconds counts, in transfer order
  class seconds_tracker;
    logic [11:0] epoch_year;
    logic [31:0] pending_totals[$];
    int unsigned fail_count;
    int unsigned month_len[12];

    function new();
      epoch_year  = dts_pkg::EPOCH_RESET;
      fail_count  = 0;
      month_len   = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    endfunction

    function void set_epoch(input logic [11:0] val);
      epoch_year = val;
    endfunction

    function int unsigned pending();
      return pending_totals.size();
    endfunction

    // day count is inclusive of the day of month, leap years by four only
    function logic [31:0] expected_seconds(input stamp_t s);
      logic [31:0] days;
      logic [31:0] yr;
      logic [31:0] ep;
      logic [31:0] total;
      int unsigned m;
      yr   = {20'd0, s.year};
      ep   = {20'd0, epoch_year};
      days = {27'd0, s.day};
      if (yr > ep)
        days = days + (yr - ep) * 32'd365 + ((yr + 32'd3) / 32'd4 - (ep + 32'd3) / 32'd4);
      for (m = 1; m < s.month && m <= 12; m++) begin
        days = days + month_len[m-1];
        if (m == 2 && yr[1:0] == 2'b00)
          days = days + 32'd1;
      end
      total = days * 32'd24 + {27'd0, s.hour};
      total = total * 32'd60 + {26'd0, s.minute};
      total = total * 32'd60 + {26'd0, s.second};
      return total;
    endfunction

    function void note_input(input stamp_t s);
      pending_totals.push_back(expected_seconds(s));
    endfunction

    function void check_result(input logic [31:0] got);
      logic [31:0] want;
      if (pending_totals.size() == 0) begin
        $display("%0t: unexpected result transfer, total_seconds %0d", $time, got);
        fail_count++;
      end else begin
        want = pending_totals.pop_front();
        if (got !== want) begin
          $display("%0t: total_seconds mismatch, expected %0d actual %0d",
                   $time, want, got);
          fail_count++;
        end
      end
    endfunction
  endclass

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_stall;
  logic [dts_pkg::YEAR_W-1:0]    in_year;
  logic [dts_pkg::MONTH_W-1:0]   in_month;
  logic [dts_pkg::DAY_W-1:0]     in_day;
  logic [dts_pkg::HOUR_W-1:0]    in_hour;
  logic [dts_pkg::MIN_W-1:0]     in_minute;
  logic [dts_pkg::SEC_W-1:0]     in_second;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [dts_pkg::OUT_W-1:0]     out_total_seconds;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [dts_pkg::PADDR_W-1:0]   paddr;
  logic [31:0]                   pwdata;
  logic [31:0]                   prdata;
  logic                          pready;

  seconds_tracker tracker = new();
  int unsigned    cycle_count = 0;
  int unsigned    stall_mode = 0;
  int unsigned    mode_left = 0;

  date_time_to_seconds DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_year           (in_year),
    .in_month          (in_month),
    .in_day            (in_day),
    .in_hour           (in_hour),
    .in_minute         (in_minute),
    .in_second         (in_second),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_total_seconds (out_total_seconds),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL date_time_to_seconds");
      $finish;
    end
  end

  // watch both channels for transfers
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall)
        tracker.note_input(stamp_of(in_year, in_month, in_day, in_hour, in_minute, in_second));
      if (out_valid && !out_stall)
        tracker.check_result(out_total_seconds);
    end
  end

  // receiver stall pattern: switches between free, random, heavy and periodic
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      mode_left <= 0;
      stall_mode <= 0;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 3);
        mode_left  <= $urandom_range(20, 80);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 1) == 0);
        2:       out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= (cycle_count % 3 == 0);
      endcase
    end
  end

  function automatic stamp_t stamp_of(
    input logic [dts_pkg::YEAR_W-1:0]  yr,
    input logic [dts_pkg::MONTH_W-1:0] mo,
    input logic [dts_pkg::DAY_W-1:0]   dy,
    input logic [dts_pkg::HOUR_W-1:0]  hr,
    input logic [dts_pkg::MIN_W-1:0]   mi,
    input logic [dts_pkg::SEC_W-1:0]   se
  );
    stamp_t s;
    s.year   = yr;
    s.month  = mo;
    s.day    = dy;
    s.hour   = hr;
    s.minute = mi;
    s.second = se;
    return s;
  endfunction

  // mostly plausible calendar times, some anywhere in the field widths
  function automatic stamp_t random_stamp();
    stamp_t s;
    if ($urandom_range(0, 3) != 0) begin
      s.year   = 12'($urandom_range(1950, 2080));
      s.month  = 4'($urandom_range(1, 12));
      s.day    = 5'($urandom_range(1, 31));
      s.hour   = 5'($urandom_range(0, 23));
      s.minute = 6'($urandom_range(0, 59));
      s.second = 6'($urandom_range(0, 59));
    end else begin
      s.year   = 12'($urandom_range(0, 4095));
      s.month  = 4'($urandom);
      s.day    = 5'($urandom);
      s.hour   = 5'($urandom);
      s.minute = 6'($urandom);
      s.second = 6'($urandom);
    end
    return s;
  endfunction

  // one input transfer; valid stays high if the caller sends again at once
  task automatic send_stamp(input stamp_t s);
    @(negedge clk);
    in_valid  <= 1'b1;
    in_year   <= s.year;
    in_month  <= s.month;
    in_day    <= s.day;
    in_hour   <= s.hour;
    in_minute <= s.minute;
    in_second <= s.second;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic pause_sender(input int unsigned gap);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (gap - 1) @(negedge clk);
  endtask

  // wait until every expected result has come out
  task automatic drain_results();
    pause_sender(1);
    while (tracker.pending() != 0) @(posedge clk);
    repeat (PIPE_DRAIN) @(posedge clk);
  endtask

  // epoch register write, then read back
  task automatic write_epoch(input logic [11:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= EPOCH_ADDR;
    pwdata  <= {20'd0, val};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[11:0] !== val) begin
      $display("%0t: epoch_year readback mismatch, expected %0d actual %0d",
               $time, val, prdata[11:0]);
      tracker.fail_count++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    tracker.set_epoch(val);
  endtask

  // bursts of random length with random gaps
  task automatic run_random(input int unsigned count);
    int unsigned sent;
    int unsigned burst;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 12);
      while (burst > 0 && sent < count) begin
        send_stamp(random_stamp());
        sent++;
        burst--;
      end
      if ($urandom_range(0, 3) != 0)
        pause_sender($urandom_range(1, 6));
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_year   = '0;
    in_month  = '0;
    in_day    = '0;
    in_hour   = '0;
    in_minute = '0;
    in_second = '0;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed timestamps against the reset epoch
    send_stamp(stamp_of(12'd1970, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0));     // first day of epoch
    send_stamp(stamp_of(12'd1969, 4'd6, 5'd15, 5'd12, 6'd30, 6'd30)); // year before epoch
    send_stamp(stamp_of(12'd0, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0));
    send_stamp(stamp_of(12'd1972, 4'd3, 5'd1, 5'd0, 6'd0, 6'd0));     // leap february passed
    send_stamp(stamp_of(12'd1973, 4'd3, 5'd1, 5'd0, 6'd0, 6'd0));
    send_stamp(stamp_of(12'd2000, 4'd2, 5'd29, 5'd23, 6'd59, 6'd59));
    send_stamp(stamp_of(12'd2100, 4'd3, 5'd1, 5'd0, 6'd0, 6'd0));     // century still leap
    send_stamp(stamp_of(12'd2101, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0));
    send_stamp(stamp_of(12'd1980, 4'd0, 5'd10, 5'd1, 6'd2, 6'd3));    // month zero
    send_stamp(stamp_of(12'd1980, 4'd13, 5'd1, 5'd0, 6'd0, 6'd0));    // month past twelve
    send_stamp(stamp_of(12'd1981, 4'd15, 5'd31, 5'd31, 6'd63, 6'd63));
    send_stamp(stamp_of(12'd1990, 4'd12, 5'd0, 5'd0, 6'd0, 6'd0));    // day zero
    send_stamp(stamp_of(12'd1990, 4'd7, 5'd31, 5'd31, 6'd63, 6'd63)); // time fields past range
    send_stamp(stamp_of(12'd1950, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0));
    send_stamp(stamp_of(12'd2080, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59));
    send_stamp(stamp_of(12'd2038, 4'd1, 5'd19, 5'd3, 6'd14, 6'd7));
    send_stamp(stamp_of(12'd4095, 4'd15, 5'd31, 5'd31, 6'd63, 6'd63)); // wraps past 2^32
    send_stamp(stamp_of(12'd2048, 4'd11, 5'd30, 5'd16, 6'd45, 6'd1));
    send_stamp(stamp_of(12'd1971, 4'd5, 5'd20, 5'd8, 6'd0, 6'd59));
    send_stamp(stamp_of(12'd2000, 4'd12, 5'd31, 5'd0, 6'd0, 6'd0));
    drain_results();

    // random phases over several epochs
    run_random(PHASE_ITEMS);
    drain_results();
    write_epoch(12'd1950);
    run_random(PHASE_ITEMS);
    drain_results();
    write_epoch(12'd2080);
    run_random(PHASE_ITEMS);
    drain_results();
    write_epoch(12'd0);
    run_random(PHASE_ITEMS);
    drain_results();
    write_epoch(12'd4095);
    run_random(PHASE_ITEMS);
    drain_results();
    write_epoch(12'($urandom_range(1950, 2080)));
    run_random(PHASE_ITEMS);
    drain_results();

    // nothing may stay outstanding
    if (tracker.pending() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, tracker.pending());
      tracker.fail_count++;
    end
    if (tracker.fail_count == 0)
      $display("PASS date_time_to_seconds");
    else
      $display("FAIL date_time_to_seconds");
    $finish;
  end

endmodule

`default_nettype wire
